### hdl/apdp_pkg.sv
`timescale 1ns / 1ps

package apdp_pkg;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_FLAGS_A  = 4'd1,
    PH_FLAGS_B  = 4'd2,
    PH_LANG     = 4'd3,
    PH_MSG      = 4'd4,
    PH_AUXCNT   = 4'd5,
    PH_AUXTAG   = 4'd6,
    PH_EXTLEN   = 4'd7,
    PH_EXTSKIP  = 4'd8,
    PH_DONE     = 4'd9,
    PH_COMPLETE = 4'd15
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EARLY_END = 2'd1,
    ST_ZERO      = 2'd2,
    ST_TRUNC     = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_payload;
  } in_t;

  typedef struct packed {
    logic [4:0]  presel_id;
    logic [2:0]  rendering_indication;
    logic [3:0]  role_flags;
    logic [3:0]  presence_flags;
    logic [23:0] language_code;
    logic [7:0]  label_msg_id;
    logic [2:0]  aux_count;
    logic [55:0] aux_tags;
    logic [4:0]  extension_length;
    logic [1:0]  status;
    logic        last_result;
  } out_t;

  typedef struct packed {
    logic [7:0]  flags_a;
    logic [7:0]  flags_b;
    logic [23:0] language;
    logic [7:0]  label_msg_id;
    logic [2:0]  aux_count;
    logic [4:0]  ext_len;
    logic [55:0] aux_tags;
  } entry_t;

  typedef struct packed {
    phase_t      phase;
    logic [4:0]  entries_left;
    logic [4:0]  bytes_left;
    entry_t      entry;
  } state_t;

endpackage

### hdl/audio_preselection_descriptor_parser.sv
`timescale 1ns / 1ps
// channel | handshake               | beat
// in      | in_valid / in_stall     | apdp_pkg::in_t  (payload_byte, end_of_payload)
// out     | out_valid / out_stall   | apdp_pkg::out_t (one entry or status result)
// One byte per cycle while in_stall is low: the state updates when a beat is taken,
// and a result lands in the output register on the same edge unless it is stalled.
// A result that meets a stalled output register goes to a one-beat skid
// register; in_stall rises only while that skid register is full.
// rst is synchronous and returns the parser to the header phase with both
// result registers empty.

module audio_preselection_descriptor_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  apdp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output apdp_pkg::out_t out_data
);

  apdp_pkg::state_t state;
  apdp_pkg::state_t state_next;
  logic             res_valid;
  apdp_pkg::out_t   res;
  logic             skid_valid;
  apdp_pkg::out_t   skid_data;
  logic             accept;
  logic             out_take;
  logic             out_valid_next;
  logic             skid_valid_next;

  apdp_step u_step (
    .cur       (state),
    .in_data   (in_data),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  assign in_stall = skid_valid;
  assign accept   = in_valid & ~skid_valid;
  assign out_take = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= apdp_pkg::PH_HEADER;
      state.entries_left <= 5'd0;
      state.bytes_left   <= 5'd0;
      state.entry        <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_comb begin
    out_valid_next  = out_valid;
    skid_valid_next = skid_valid;
    if (out_take) begin
      if (skid_valid) begin
        skid_valid_next = 1'b0;
      end else begin
        out_valid_next = 1'b0;
      end
    end
    if (accept && res_valid) begin
      if (out_valid && !out_take) begin
        skid_valid_next = 1'b1;
      end else begin
        out_valid_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      skid_valid <= skid_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && skid_valid) begin
      out_data <= skid_data;
    end else if (accept && res_valid && !(out_valid && !out_take)) begin
      out_data <= res;
    end
    if (accept && res_valid && out_valid && !out_take) begin
      skid_data <= res;
    end
  end

endmodule

### hdl/apdp_step.sv
`timescale 1ns / 1ps

module apdp_step (
  input  apdp_pkg::state_t cur,
  input  apdp_pkg::in_t    in_data,
  output apdp_pkg::state_t nxt,
  output logic             res_valid,
  output apdp_pkg::out_t   res
);

  localparam logic [4:0] LangBytes = 5'd3;

  logic [7:0] b;
  logic       eop;
  logic       check_end;
  logic [4:0] bl_dec;
  logic [4:0] left_dec;
  logic [4:0] idx_diff;
  logic [2:0] idx;
  logic [2:0] cnt;

  function automatic apdp_pkg::phase_t next_part(input logic [1:0] rank,
                                                 input logic [3:0] pres);
    if (rank < 2'd1 && pres[3]) begin
      return apdp_pkg::PH_LANG;
    end else if (rank < 2'd2 && pres[2]) begin
      return apdp_pkg::PH_MSG;
    end else if (rank < 2'd3 && pres[1]) begin
      return apdp_pkg::PH_AUXCNT;
    end else if (pres[0]) begin
      return apdp_pkg::PH_EXTLEN;
    end
    return apdp_pkg::PH_COMPLETE;
  endfunction

  function automatic apdp_pkg::out_t pack_entry(input apdp_pkg::entry_t e);
    apdp_pkg::out_t o;
    o.presel_id            = e.flags_a[7:3];
    o.rendering_indication = e.flags_a[2:0];
    o.role_flags           = e.flags_b[7:4];
    o.presence_flags       = e.flags_b[3:0];
    o.language_code        = e.language;
    o.label_msg_id         = e.label_msg_id;
    o.aux_count            = e.aux_count;
    o.aux_tags             = e.aux_tags;
    o.extension_length     = e.ext_len;
    o.status               = apdp_pkg::ST_OK;
    o.last_result          = 1'b0;
    return o;
  endfunction

  assign b        = in_data.payload_byte;
  assign eop      = in_data.end_of_payload;
  assign bl_dec   = (cur.bytes_left != 5'd0) ? cur.bytes_left - 5'd1 : 5'd0;
  assign cnt      = cur.entry.aux_count;
  assign idx_diff = {2'b00, cnt} - cur.bytes_left;

  always_comb begin
    if ({2'b00, cnt} < cur.bytes_left) begin
      idx = 3'd0;
    end else if (idx_diff > 5'd6) begin
      idx = 3'd6;
    end else begin
      idx = idx_diff[2:0];
    end
  end

  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    check_end = 1'b1;
    left_dec  = 5'd0;
    case (cur.phase)
      apdp_pkg::PH_HEADER: begin
        nxt.entry        = '0;
        nxt.bytes_left   = 5'd0;
        nxt.entries_left = b[7:3];
        if (b[7:3] == 5'd0) begin
          res_valid       = 1'b1;
          res.status      = apdp_pkg::ST_ZERO;
          res.last_result = 1'b1;
          nxt.phase       = eop ? apdp_pkg::PH_HEADER : apdp_pkg::PH_DONE;
          check_end       = 1'b0;
        end else begin
          nxt.phase = apdp_pkg::PH_FLAGS_A;
        end
      end
      apdp_pkg::PH_FLAGS_A: begin
        nxt.entry.flags_a = b;
        nxt.phase         = apdp_pkg::PH_FLAGS_B;
      end
      apdp_pkg::PH_FLAGS_B: begin
        nxt.entry.flags_b = b;
        nxt.phase         = next_part(2'd0, b[3:0]);
        if (b[3]) begin
          nxt.bytes_left = LangBytes;
        end
      end
      apdp_pkg::PH_LANG: begin
        nxt.entry.language = {cur.entry.language[15:0], b};
        nxt.bytes_left     = bl_dec;
        if (bl_dec == 5'd0) begin
          nxt.phase = next_part(2'd1, cur.entry.flags_b[3:0]);
        end
      end
      apdp_pkg::PH_MSG: begin
        nxt.entry.label_msg_id = b;
        nxt.phase              = next_part(2'd2, cur.entry.flags_b[3:0]);
      end
      apdp_pkg::PH_AUXCNT: begin
        nxt.entry.aux_count = b[7:5];
        if (b[7:5] != 3'd0) begin
          nxt.bytes_left = {2'b00, b[7:5]};
          nxt.phase      = apdp_pkg::PH_AUXTAG;
        end else begin
          nxt.phase = next_part(2'd3, cur.entry.flags_b[3:0]);
        end
      end
      apdp_pkg::PH_AUXTAG: begin
        nxt.entry.aux_tags = cur.entry.aux_tags
                           | (56'(b) << {3'(3'd6 - idx), 3'b000});
        nxt.bytes_left     = bl_dec;
        if (bl_dec == 5'd0) begin
          nxt.phase = next_part(2'd3, cur.entry.flags_b[3:0]);
        end
      end
      apdp_pkg::PH_EXTLEN: begin
        nxt.entry.ext_len = b[4:0];
        if (b[4:0] != 5'd0) begin
          nxt.bytes_left = b[4:0];
          nxt.phase      = apdp_pkg::PH_EXTSKIP;
        end else begin
          nxt.phase = apdp_pkg::PH_COMPLETE;
        end
      end
      apdp_pkg::PH_EXTSKIP: begin
        nxt.bytes_left = bl_dec;
        if (bl_dec == 5'd0) begin
          nxt.phase = apdp_pkg::PH_COMPLETE;
        end
      end
      default: begin
        check_end = 1'b0;
        if (eop) begin
          nxt.phase = apdp_pkg::PH_HEADER;
        end
      end
    endcase

    if (check_end) begin
      if (nxt.phase == apdp_pkg::PH_COMPLETE) begin
        left_dec  = (cur.entries_left != 5'd0) ? cur.entries_left - 5'd1 : 5'd0;
        res_valid = 1'b1;
        res       = pack_entry(nxt.entry);
        if (left_dec == 5'd0) begin
          res.status       = apdp_pkg::ST_OK;
          res.last_result  = 1'b1;
          nxt.phase        = eop ? apdp_pkg::PH_HEADER : apdp_pkg::PH_DONE;
          nxt.entries_left = 5'd0;
        end else if (eop) begin
          res.status       = apdp_pkg::ST_EARLY_END;
          res.last_result  = 1'b1;
          nxt.phase        = apdp_pkg::PH_HEADER;
          nxt.entries_left = 5'd0;
        end else begin
          res.status       = apdp_pkg::ST_OK;
          res.last_result  = 1'b0;
          nxt.phase        = apdp_pkg::PH_FLAGS_A;
          nxt.entries_left = left_dec;
        end
        nxt.bytes_left = 5'd0;
        nxt.entry      = '0;
      end else if (eop) begin
        res_valid        = 1'b1;
        res              = pack_entry(nxt.entry);
        res.status       = apdp_pkg::ST_TRUNC;
        res.last_result  = 1'b1;
        nxt.phase        = apdp_pkg::PH_HEADER;
        nxt.entries_left = 5'd0;
        nxt.bytes_left   = 5'd0;
        nxt.entry        = '0;
      end
    end
  end

endmodule

### hdl/apdp_checker.sv
`timescale 1ns / 1ps

module apdp_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_valid,
  input logic           in_stall,
  input apdp_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input apdp_pkg::out_t out_data
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // input backpressure only behind a waiting result
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // skid fills only from a beat that met a stalled output
  assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(in_valid && out_valid && out_stall))
    else $error("skid filled without a stalled output");

endmodule

bind audio_preselection_descriptor_parser apdp_checker u_apdp_checker (.*);

### bench/preselection_checker.sv
`timescale 1ns / 1ps

module preselection_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_stall,
  input  apdp_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  apdp_pkg::out_t out_data,
  output int             mismatches,
  output int             outstanding,
  output int             results_seen
);

  apdp_pkg::phase_t phase;
  logic [4:0]       entries_left;
  logic [4:0]       bytes_left;
  apdp_pkg::entry_t ent;
  apdp_pkg::out_t   due_results[$];

  function automatic apdp_pkg::out_t entry_result(input apdp_pkg::status_t st,
                                                  input logic last);
    apdp_pkg::out_t r;
    r.presel_id            = ent.flags_a[7:3];
    r.rendering_indication = ent.flags_a[2:0];
    r.role_flags           = ent.flags_b[7:4];
    r.presence_flags       = ent.flags_b[3:0];
    r.language_code        = ent.language;
    r.label_msg_id         = ent.label_msg_id;
    r.aux_count            = ent.aux_count;
    r.aux_tags             = ent.aux_tags;
    r.extension_length     = ent.ext_len;
    r.status               = st;
    r.last_result          = last;
    return r;
  endfunction

  task automatic queue_result(input apdp_pkg::out_t r);
    due_results.insert(due_results.size(), r);
  endtask

  task automatic pick_next_part(input int rank);
    logic [3:0] pres;
    pres = ent.flags_b[3:0];
    if (rank < 1 && pres[3]) begin
      phase      = apdp_pkg::PH_LANG;
      bytes_left = 5'd3;
    end else if (rank < 2 && pres[2]) begin
      phase = apdp_pkg::PH_MSG;
    end else if (rank < 3 && pres[1]) begin
      phase = apdp_pkg::PH_AUXCNT;
    end else if (pres[0]) begin
      phase = apdp_pkg::PH_EXTLEN;
    end else begin
      phase = apdp_pkg::PH_COMPLETE;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic eop);
    int idx;
    int cnt;
    case (phase)
      apdp_pkg::PH_HEADER: begin
        ent          = '0;
        bytes_left   = 5'd0;
        entries_left = b[7:3];
        if (b[7:3] == 5'd0) begin
          queue_result(entry_result(apdp_pkg::ST_ZERO, 1'b1));
          if (eop) phase = apdp_pkg::PH_HEADER;
          else phase = apdp_pkg::PH_DONE;
          return;
        end
        phase = apdp_pkg::PH_FLAGS_A;
      end
      apdp_pkg::PH_FLAGS_A: begin
        ent.flags_a = b;
        phase       = apdp_pkg::PH_FLAGS_B;
      end
      apdp_pkg::PH_FLAGS_B: begin
        ent.flags_b = b;
        pick_next_part(0);
      end
      apdp_pkg::PH_LANG: begin
        ent.language = {ent.language[15:0], b};
        if (bytes_left > 0) bytes_left = bytes_left - 5'd1;
        if (bytes_left == 0) pick_next_part(1);
      end
      apdp_pkg::PH_MSG: begin
        ent.label_msg_id = b;
        pick_next_part(2);
      end
      apdp_pkg::PH_AUXCNT: begin
        ent.aux_count = b[7:5];
        if (b[7:5] != 3'd0) begin
          bytes_left = {2'b00, b[7:5]};
          phase      = apdp_pkg::PH_AUXTAG;
        end else begin
          pick_next_part(3);
        end
      end
      apdp_pkg::PH_AUXTAG: begin
        cnt = int'(ent.aux_count);
        idx = (cnt >= int'(bytes_left)) ? cnt - int'(bytes_left) : 0;
        if (idx > 6) idx = 6;
        ent.aux_tags = ent.aux_tags | (56'(b) << (48 - 8 * idx));
        if (bytes_left > 0) bytes_left = bytes_left - 5'd1;
        if (bytes_left == 0) pick_next_part(3);
      end
      apdp_pkg::PH_EXTLEN: begin
        ent.ext_len = b[4:0];
        if (b[4:0] != 5'd0) begin
          bytes_left = b[4:0];
          phase      = apdp_pkg::PH_EXTSKIP;
        end else begin
          phase = apdp_pkg::PH_COMPLETE;
        end
      end
      apdp_pkg::PH_EXTSKIP: begin
        if (bytes_left > 0) bytes_left = bytes_left - 5'd1;
        if (bytes_left == 0) phase = apdp_pkg::PH_COMPLETE;
      end
      default: begin
        if (eop) phase = apdp_pkg::PH_HEADER;
        return;
      end
    endcase

    if (phase == apdp_pkg::PH_COMPLETE) begin
      if (entries_left > 0) entries_left = entries_left - 5'd1;
      if (entries_left == 0) begin
        queue_result(entry_result(apdp_pkg::ST_OK, 1'b1));
        if (eop) phase = apdp_pkg::PH_HEADER;
        else phase = apdp_pkg::PH_DONE;
      end else if (eop) begin
        queue_result(entry_result(apdp_pkg::ST_EARLY_END, 1'b1));
        phase        = apdp_pkg::PH_HEADER;
        entries_left = 5'd0;
      end else begin
        queue_result(entry_result(apdp_pkg::ST_OK, 1'b0));
        phase = apdp_pkg::PH_FLAGS_A;
      end
      bytes_left = 5'd0;
      ent        = '0;
    end else if (eop) begin
      queue_result(entry_result(apdp_pkg::ST_TRUNC, 1'b1));
      phase        = apdp_pkg::PH_HEADER;
      entries_left = 5'd0;
      bytes_left   = 5'd0;
      ent          = '0;
    end
  endtask

  task automatic cmp_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    apdp_pkg::out_t want;
    if (rst) begin
      phase        = apdp_pkg::PH_HEADER;
      entries_left = 5'd0;
      bytes_left   = 5'd0;
      ent          = '0;
      due_results.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = due_results.pop_front();
          cmp_field("presel_id", 64'(want.presel_id), 64'(out_data.presel_id));
          cmp_field("rendering_indication", 64'(want.rendering_indication),
                    64'(out_data.rendering_indication));
          cmp_field("role_flags", 64'(want.role_flags), 64'(out_data.role_flags));
          cmp_field("presence_flags", 64'(want.presence_flags),
                    64'(out_data.presence_flags));
          cmp_field("language_code", 64'(want.language_code),
                    64'(out_data.language_code));
          cmp_field("label_msg_id", 64'(want.label_msg_id), 64'(out_data.label_msg_id));
          cmp_field("aux_count", 64'(want.aux_count), 64'(out_data.aux_count));
          cmp_field("aux_tags", 64'(want.aux_tags), 64'(out_data.aux_tags));
          cmp_field("extension_length", 64'(want.extension_length),
                    64'(out_data.extension_length));
          cmp_field("status", 64'(want.status), 64'(out_data.status));
          cmp_field("last_result", 64'(want.last_result), 64'(out_data.last_result));
        end
      end
      if (in_valid && !in_stall)
        parse_byte(in_data.payload_byte, in_data.end_of_payload);
    end
    outstanding <= due_results.size();
  end

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_mode_t;

  localparam int IDLE_LIMIT = 4000;
  localparam int BYTE_TARGET = 1750;

  logic           clk;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  apdp_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  apdp_pkg::out_t out_data;

  int mismatches;
  int outstanding;
  int results_seen;

  int       burst_left = 0;
  bit       calm = 1'b0;
  int       bytes_sent = 0;
  int       payloads_sent = 0;
  int       idle_cycles = 0;
  int       stall_tick = 0;
  rx_mode_t stall_mode = RX_OPEN;

  logic [7:0] payload_q[$];
  int         entry_ends[$];

  audio_preselection_descriptor_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  preselection_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_tick <= 0;
    end else begin
      stall_tick <= stall_tick + 1;
      if (stall_tick % 150 == 0) stall_mode <= rx_mode_t'($urandom_range(0, 3));
      if (calm) begin
        out_stall <= 1'b0;
      end else begin
        case (stall_mode)
          RX_OPEN:     out_stall <= 1'b0;
          RX_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
          RX_PERIODIC: out_stall <= (stall_tick % 7) < 3;
          default:     out_stall <= (stall_tick % 64) >= 40;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [7:0] rbyte();
    return 8'($urandom);
  endfunction

  task automatic add_byte(input logic [7:0] b);
    payload_q.insert(payload_q.size(), b);
  endtask

  task automatic put_byte(input logic [7:0] b, input logic eop);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = calm ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= {b, eop};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_payload();
    for (int i = 0; i < payload_q.size(); i++)
      put_byte(payload_q[i], i == payload_q.size() - 1);
    payload_q.delete();
    payloads_sent++;
  endtask

  task automatic add_entry(input logic [3:0] pres, input int auxn, input int extn);
    add_byte(rbyte());
    add_byte({4'($urandom), pres});
    if (pres[3]) repeat (3) add_byte(rbyte());
    if (pres[2]) add_byte(rbyte());
    if (pres[1]) begin
      add_byte({3'(auxn), 5'($urandom)});
      repeat (auxn) add_byte(rbyte());
    end
    if (pres[0]) begin
      add_byte({3'($urandom), 5'(extn)});
      repeat (extn) add_byte(rbyte());
    end
  endtask

  task automatic random_descriptor();
    int kind;
    int n;
    int cut;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      n = $urandom_range(1, 24);
      repeat (n) add_byte(rbyte());
    end else if (kind < 18) begin
      add_byte({5'd0, 3'($urandom)});
      repeat ($urandom_range(0, 4)) add_byte(rbyte());
    end else begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 31) : $urandom_range(1, 4);
      add_byte({5'(n), 3'($urandom)});
      entry_ends.delete();
      for (int i = 0; i < n; i++) begin
        if (n >= 20)
          add_entry(4'($urandom), $urandom_range(0, 1), 0);
        else
          add_entry(4'($urandom), $urandom_range(0, 7),
                    ($urandom_range(0, 9) == 0) ? 31 : $urandom_range(0, 4));
        entry_ends.insert(entry_ends.size(), payload_q.size());
      end
      kind = $urandom_range(0, 9);
      if (kind == 6) begin
        repeat ($urandom_range(1, 6)) add_byte(rbyte());
      end else if (kind >= 7 && kind <= 8) begin
        cut = $urandom_range(1, payload_q.size() - 1);
        while (payload_q.size() > cut) void'(payload_q.pop_back());
      end else if (kind == 9 && n > 1) begin
        cut = entry_ends[$urandom_range(0, n - 2)];
        while (payload_q.size() > cut) void'(payload_q.pop_back());
      end
    end
    send_payload();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    payload_q = '{8'h07};
    send_payload();
    payload_q = '{8'hF8};
    send_payload();
    payload_q = '{8'h08, 8'hFF, 8'hFF, 8'h41, 8'h42, 8'h43, 8'h99, 8'hFF,
                  8'h80, 8'hFF, 8'h01, 8'h7F, 8'h55, 8'hAA, 8'hFE, 8'hE0};
    send_payload();
    payload_q = '{8'h10, 8'h00, 8'h02, 8'h1F};
    send_payload();

    while (bytes_sent < BYTE_TARGET) begin
      if ($urandom_range(0, 7) == 0) calm = !calm;
      random_descriptor();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Parsed %0d payload bytes over %0d descriptors; %0d result beats compared.",
             bytes_sent, payloads_sent, results_seen);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
